// ===== design/sesz_pkg.sv =====
// ----------------------------------------------------------------------------
// Subset enumerator package
// Types and field widths shared by the enumerator, its channels and checker.
// ----------------------------------------------------------------------------
package sesz_pkg;

    localparam int SIZE_W = 5;
    localparam int COUNT_W = 5;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [COUNT_W-1:0] elem_count_t;

    typedef enum logic
    {
        OP_ADVANCE = 1'b0,
        OP_START   = 1'b1
    } opcode_t;

endpackage

// ===== design/sesz_channels.sv =====
// ----------------------------------------------------------------------------
// Subset enumerator channels
// Valid/ready channels for commands, results and the configuration write.
// ----------------------------------------------------------------------------
interface sesz_cmd_if;
    logic              valid;
    logic              ready;
    sesz_pkg::opcode_t opcode;
    sesz_pkg::size_t   start_size;

    modport source (output valid, output opcode, output start_size, input ready);
    modport sink (input valid, input opcode, input start_size, output ready);
endinterface

interface sesz_res_if #(parameter int MASK_W = 16);
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] subset_mask;
    sesz_pkg::size_t   subset_size;
    logic              wrapped;

    modport source (output valid, output subset_mask, output subset_size,
                    output wrapped, input ready);
    modport sink (input valid, input subset_mask, input subset_size,
                  input wrapped, output ready);
endinterface

interface sesz_cfg_if;
    logic                  valid;
    logic                  ready;
    sesz_pkg::elem_count_t element_count;

    modport source (output valid, output element_count, input ready);
    modport sink (input valid, input element_count, output ready);
endinterface

// ===== design/subset_enumerator_by_size_core.sv =====
// ----------------------------------------------------------------------------
// Subset enumerator by size
// A command word is captured in the input register; its result updates the held
// subset in the result register. One command word per cycle while the result
// channel is not stalled.
// Reset clears the held subset, its size, the started flag and the element
// count; no result is pending after reset.
// ----------------------------------------------------------------------------
module subset_enumerator_by_size_core #(
    parameter int MAX_ELEMENTS = 16
) (
    input logic          clk,
    input logic          rst_n,
    sesz_cfg_if.sink     cfg,
    sesz_cmd_if.sink     cmd,
    sesz_res_if.source   result
);
    import sesz_pkg::*;

    localparam int W    = MAX_ELEMENTS;
    localparam int IW   = (W > 1) ? $clog2(W) : 1;
    localparam int CW   = $clog2(W + 1);
    localparam int GRP  = 8;
    localparam int NGRP = (W + GRP - 1) / GRP;

    typedef logic [W-1:0]  mask_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [IW-1:0] idx_t;

    function automatic cnt_t popcount(input mask_t v);
        cnt_t grp;
        cnt_t total;
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp = '0;
            for (int b = 0; b < GRP; b++)
            begin
                if (g * GRP + b < W)
                begin
                    grp = grp + CW'(v[g * GRP + b]);
                end
            end
            total = total + grp;
        end
        return total;
    endfunction

    function automatic mask_t low_mask(input cnt_t k);
        mask_t r;
        for (int j = 0; j < W; j++)
        begin
            r[j] = (j < int'(k));
        end
        return r;
    endfunction

    elem_count_t element_count_reg;

    logic    s1_valid_reg;
    opcode_t s1_op_reg;
    size_t   s1_size_reg;

    logic  res_valid_reg;
    mask_t mask_reg;
    cnt_t  count_reg;
    logic  wrapped_reg;
    logic  started_reg;

    logic  fire;
    cnt_t  n;
    cnt_t  start_cnt;
    mask_t m;
    cnt_t  k;
    mask_t cand;
    logic  found;
    idx_t  b;
    mask_t hi;
    cnt_t  above;
    int    top;
    mask_t adv_mask;
    mask_t mask_next;
    cnt_t  count_next;
    logic  wrapped_next;

    assign fire      = s1_valid_reg && (!res_valid_reg || result.ready);
    assign cmd.ready = !s1_valid_reg || fire;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        n = (int'(element_count_reg) > W) ? CW'(W) : CW'(element_count_reg);
        start_cnt = (int'(s1_size_reg) > int'(n)) ? n : CW'(s1_size_reg);
        m = mask_reg & low_mask(n);
        k = popcount(m);

        for (int p = 0; p < W; p++)
        begin
            if (p + 1 < W)
            begin
                cand[p] = m[p] && !m[p + 1] && (p + 1 < int'(n));
            end
            else
            begin
                cand[p] = 1'b0;
            end
        end
        found = |cand;

        b = '0;
        for (int p = 0; p < W; p++)
        begin
            if (cand[p])
            begin
                b = IW'(p);
            end
        end

        for (int j = 0; j < W; j++)
        begin
            hi[j] = (j > int'(b));
        end
        above = popcount(m & hi);
        top = int'(b) + 1 + int'(above);

        for (int j = 0; j < W; j++)
        begin
            if (j < int'(b))
            begin
                adv_mask[j] = m[j];
            end
            else
            begin
                adv_mask[j] = (j > int'(b)) && (j <= top);
            end
        end

        wrapped_next = 1'b0;
        priority if (s1_op_reg == OP_START)
        begin
            mask_next  = low_mask(start_cnt);
            count_next = start_cnt;
        end
        else if (!started_reg || n == '0)
        begin
            mask_next  = '0;
            count_next = '0;
        end
        else if (found)
        begin
            mask_next  = adv_mask;
            count_next = k;
        end
        else if (k >= n)
        begin
            mask_next    = '0;
            count_next   = '0;
            wrapped_next = 1'b1;
        end
        else
        begin
            mask_next  = low_mask(k + CW'(1));
            count_next = k + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= '0;
            s1_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
            mask_reg          <= '0;
            count_reg         <= '0;
            wrapped_reg       <= 1'b0;
            started_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                element_count_reg <= cfg.element_count;
            end

            if (cmd.valid && cmd.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                res_valid_reg <= 1'b1;
                mask_reg      <= mask_next;
                count_reg     <= count_next;
                wrapped_reg   <= wrapped_next;
                started_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_op_reg   <= cmd.opcode;
            s1_size_reg <= cmd.start_size;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.subset_mask = mask_reg;
    assign result.subset_size = size_t'(count_reg);
    assign result.wrapped     = wrapped_reg;

endmodule

// ===== design/sesz_checker.sv =====
// ----------------------------------------------------------------------------
// Subset enumerator checker
// Port-level properties of the enumerator, attached to the core by bind.
// ----------------------------------------------------------------------------
module sesz_checker #(
    parameter int MAX_ELEMENTS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic [MAX_ELEMENTS-1:0] res_mask,
    input sesz_pkg::size_t         res_size,
    input logic                    res_wrapped
);
    import sesz_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mask)
            && $stable(res_size) && $stable(res_wrapped))
        else $error("Stalled result word changed.");

    a_size_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $countones(res_mask) == int'(res_size))
        else $error("Result size does not match the mask population.");

    a_wrap_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_wrapped |-> res_mask == '0 && res_size == '0)
        else $error("Wrapped result is not the empty set.");

    a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("Result word appeared without an accepted command word.");

endmodule

bind subset_enumerator_by_size_core sesz_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
) u_sesz_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd.valid),
    .cmd_ready(cmd.ready),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .res_mask(result.subset_mask),
    .res_size(result.subset_size),
    .res_wrapped(result.wrapped)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subset enumerator by size testbench
// Drives command words under random gaps and result back-pressure. Every result
// word is compared with a listed word or an in-line model of the enumeration
// order. The element count is rewritten between bursts while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    import sesz_pkg::*;

    localparam int MAX_ELEMENTS = 16;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_DIRECTED = 28;
    localparam int NUM_PHASES = 14;
    localparam int RANDOM_COUNT = -1;

    typedef struct packed {
        logic [MAX_ELEMENTS-1:0] mask;
        size_t                   size;
        logic                    wrapped;
    } subset_word_t;

    typedef enum logic [1:0]
    {
        ROW_SEND,
        ROW_SEND_KNOWN,
        ROW_SET_COUNT
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        opcode_t      op;
        logic [4:0]   arg;
        subset_word_t known;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    sesz_cfg_if                         cfg_ch ();
    sesz_cmd_if                         cmd_ch ();
    sesz_res_if #(.MASK_W(MAX_ELEMENTS)) res_ch ();

    subset_enumerator_by_size_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    elem_count_t             held_elems = '0;
    logic [MAX_ELEMENTS-1:0] held_mask = '0;
    size_t                   held_count = '0;
    logic                    enum_started = 1'b0;

    subset_word_t pending_subsets [$];
    int           failures = 0;
    int           quiet_cycles = 0;
    int           send_run_left = 0;
    bit           send_run_quiet = 1'b0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND_KNOWN, OP_START,   5'd5,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SET_COUNT,  OP_ADVANCE, 5'd3,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0001, 5'd1,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd31, '{16'h0002, 5'd1,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0004, 5'd1,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0003, 5'd2,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0005, 5'd2,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0006, 5'd2,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0007, 5'd3,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b1}},
        '{ROW_SEND_KNOWN, OP_START,   5'd31, '{16'h0007, 5'd3,  1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b1}},
        '{ROW_SET_COUNT,  OP_ADVANCE, 5'd16, '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND_KNOWN, OP_START,   5'd16, '{16'hFFFF, 5'd16, 1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b1}},
        '{ROW_SEND_KNOWN, OP_START,   5'd0,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND,       OP_START,   5'd1,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND,       OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SET_COUNT,  OP_ADVANCE, 5'd31, '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND_KNOWN, OP_START,   5'd31, '{16'hFFFF, 5'd16, 1'b0}},
        '{ROW_SEND_KNOWN, OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b1}},
        '{ROW_SEND,       OP_START,   5'd10, '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SET_COUNT,  OP_ADVANCE, 5'd5,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND,       OP_ADVANCE, 5'd0,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND,       OP_START,   5'd2,  '{16'h0000, 5'd0,  1'b0}},
        '{ROW_SEND,       OP_ADVANCE, 5'd21, '{16'h0000, 5'd0,  1'b0}}
    };

    int phase_counts [NUM_PHASES] = '{
        1, 2, 16, 31, 4, 0, 7, 17, 5, RANDOM_COUNT, 3, 12, 6, RANDOM_COUNT
    };

    function automatic logic [31:0] low_ones(int k);
        return (32'd1 << k) - 32'd1;
    endfunction

    function automatic int pick_gap(inout int run_left, inout bit run_quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(8, 40);
            run_quiet = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void log_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    function automatic subset_word_t next_subset(opcode_t op, size_t size_req);
        subset_word_t nxt;
        logic [31:0]  m;
        int           n;
        int           k;
        int           b;
        int           above;
        int           i;
        n = (held_elems > MAX_ELEMENTS) ? MAX_ELEMENTS : held_elems;
        nxt.wrapped = 1'b0;
        b = -1;
        if (op == OP_START)
        begin
            k = (size_req > n) ? n : size_req;
            m = low_ones(k);
            enum_started = 1'b1;
        end
        else if (!enum_started || n == 0)
        begin
            enum_started = 1'b1;
            m = '0;
            k = 0;
        end
        else
        begin
            m = {16'h0000, held_mask} & low_ones(n);
            k = $countones(m);
            if (k == 0)
            begin
                m = 32'd1;
                k = 1;
            end
            else
            begin
                for (i = n - 1; i > 0 && b < 0; i--)
                begin
                    if (m[i-1] && !m[i])
                    begin
                        b = i - 1;
                    end
                end
                if (b >= 0)
                begin
                    above = $countones(m >> (b + 1));
                    m = (m & low_ones(b)) | (low_ones(above + 1) << (b + 1));
                end
                else if (k >= n)
                begin
                    m = '0;
                    k = 0;
                    nxt.wrapped = 1'b1;
                end
                else
                begin
                    k++;
                    m = low_ones(k);
                end
            end
        end
        held_mask = m[MAX_ELEMENTS-1:0];
        held_count = size_t'(k);
        nxt.mask = held_mask;
        nxt.size = held_count;
        return nxt;
    endfunction

    task automatic send_word(opcode_t op, size_t size_arg, bit known_given,
                             subset_word_t known);
        int           gap;
        subset_word_t predicted;
        gap = pick_gap(send_run_left, send_run_quiet);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.start_size <= size_arg;
        do @(posedge clk); while (!cmd_ch.ready);
        predicted = next_subset(op, size_arg);
        pending_subsets.push_back(known_given ? known : predicted);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_subsets.size() != 0) @(negedge clk);
    endtask

    task automatic write_element_count(elem_count_t value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.element_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        held_elems = value;
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        directed_row_t row;
        int            items;
        int            n;
        int            j;
        opcode_t       op;
        size_t         sz;
        rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.element_count <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.opcode <= OP_ADVANCE;
        cmd_ch.start_size <= '0;
        res_ch.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_SET_COUNT)
            begin
                write_element_count(row.arg);
            end
            else
            begin
                send_word(row.op, row.arg, row.kind == ROW_SEND_KNOWN, row.known);
            end
        end

        foreach (phase_counts[p])
        begin
            if (phase_counts[p] == RANDOM_COUNT)
            begin
                write_element_count(elem_count_t'($urandom_range(0, 31)));
            end
            else
            begin
                write_element_count(elem_count_t'(phase_counts[p]));
            end
            n = (held_elems > MAX_ELEMENTS) ? MAX_ELEMENTS : held_elems;
            items = $urandom_range(80, 130);
            for (j = 0; j < items; j++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    op = OP_START;
                    case ($urandom_range(0, 2))
                        0: sz = size_t'($urandom_range(0, 31));
                        1: sz = size_t'($urandom_range(0, n));
                        default: sz = size_t'((n >= 2) ? $urandom_range(n - 2, n) : n);
                    endcase
                end
                else
                begin
                    op = OP_ADVANCE;
                    sz = size_t'($urandom_range(0, 31));
                end
                send_word(op, sz, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // The receiver holds off twice for a long stretch so that the core fills.
    initial
    begin : receiver
        int stall;
        int results_seen;
        int run_left;
        bit run_quiet;
        results_seen = 0;
        run_left = 0;
        run_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap(run_left, run_quiet);
            if (results_seen == 300 || results_seen == 900)
            begin
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin : result_check
        subset_word_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_subsets.size() == 0)
            begin
                log_failure($sformatf("unexpected word: mask %h size %0d wrapped %b",
                                      res_ch.subset_mask, res_ch.subset_size,
                                      res_ch.wrapped));
            end
            else
            begin
                want = pending_subsets.pop_front();
                if (res_ch.subset_mask !== want.mask)
                begin
                    log_failure($sformatf("subset_mask: expected %h, got %h",
                                          want.mask, res_ch.subset_mask));
                end
                if (res_ch.subset_size !== want.size)
                begin
                    log_failure($sformatf("subset_size: expected %0d, got %0d",
                                          want.size, res_ch.subset_size));
                end
                if (res_ch.wrapped !== want.wrapped)
                begin
                    log_failure($sformatf("wrapped: expected %b, got %b",
                                          want.wrapped, res_ch.wrapped));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
